/* rtl/pll_divider_search_core_assert.svh */
// ---------------------------------------------------------------------------
// pll_divider_search_core assertion macros
// Shared property forms for the divider search core checks.
// ---------------------------------------------------------------------------
`ifndef PLL_DIVIDER_SEARCH_CORE_ASSERT_SVH
`define PLL_DIVIDER_SEARCH_CORE_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define PDS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition holds in the cycle after the trigger
`define PDS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/pds_pkg.sv */
// ---------------------------------------------------------------------------
// pds_pkg
// Types, constants and helpers shared by the PLL divider search core.
// ---------------------------------------------------------------------------
package pds_pkg;

	// field widths
	localparam int TARGET_W = 18;
	localparam int FB_W     = 8;
	localparam int REF_W    = 2;
	localparam int PD_W     = 3;
	localparam int BYTE_W   = 8;
	localparam int PROD_W   = 7;   // r*p1*p2 <= 98
	localparam int NUM_W    = PROD_W + TARGET_W;
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 32;

	// default fraction bits of the target
	localparam int FRAC_BITS_DEF = 8;

	// search limits
	localparam int FB_MIN      = 8'hA0;
	localparam int FB_MAX      = 8'hEF;
	localparam int REF_CLK_MHZ = 25;
	localparam int VCO_LIMIT   = 2400;
	localparam int Y_LO        = FB_MIN * REF_CLK_MHZ;
	localparam int Y_HI        = (FB_MAX + 1) * REF_CLK_MHZ;
	localparam int V_W         = 11;  // Y_HI - Y_LO < 2^11

	// divide by 25 as multiply by reciprocal, exact for v < 2000
	localparam int RECIP_M = 1311;
	localparam int RECIP_S = 15;
	localparam int Q_W     = 7;

	// start values of the candidate sweep
	localparam logic [REF_W-1:0] REF_FIRST = 2'd2;
	localparam logic [REF_W-1:0] REF_LAST  = 2'd1;
	localparam logic [PD_W-1:0]  PD_FIRST  = 3'd7;
	localparam logic [PD_W-1:0]  PD_LAST   = 3'd1;

	// controller to datapath
	typedef struct packed {
		logic             start;    // load target, clear result
		logic             issue;    // push one candidate
		logic [REF_W-1:0] ref_div;
		logic [PD_W-1:0]  pd1;
		logic [PD_W-1:0]  pd2;
		logic             out_load; // copy result to output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic found; // result latched
		logic busy;  // candidates in flight
	} sts_t;

	// one result item, lowest field in the lowest bits
	typedef struct packed {
		logic              high_vco;
		logic [BYTE_W-1:0] post_divider_byte;
		logic [PD_W-1:0]   post_divider_second;
		logic [PD_W-1:0]   post_divider_first;
		logic [REF_W-1:0]  reference_divider;
		logic [FB_W-1:0]   feedback_divider;
		logic              found;
	} res_t;

	localparam int RES_W = $bits(res_t);

	// total divider product r*p1*p2 (r is 1 or 2, a shift)
	function automatic logic [PROD_W-1:0] prod_of(input logic [REF_W-1:0] r,
			input logic [PD_W-1:0] p1, input logic [PD_W-1:0] p2);
		logic [5:0] pp;
		pp = 6'(p1) * 6'(p2);
		return r[1] ? {pp, 1'b0} : {1'b0, pp};
	endfunction

endpackage

/* rtl/pds_ctrl.sv */
// ---------------------------------------------------------------------------
// pds_ctrl
// Controller: input handshake, candidate sweep, drain and output valid.
// ---------------------------------------------------------------------------
module pds_ctrl
	import pds_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input  logic m_tready,
	output cmd_t cmd,
	input  sts_t sts
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t           state_q, state_d;
	logic [REF_W-1:0] ref_q;
	logic [PD_W-1:0]  pd1_q;
	logic [PD_W-1:0]  pd2_q;
	logic             out_vld_q;
	logic             accept;
	logic             last_cand;
	logic             out_free;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign last_cand = (ref_q == REF_LAST) && (pd1_q == PD_LAST) && (pd2_q == PD_LAST);
	assign out_free  = !out_vld_q || m_tready;
	assign m_tvalid  = out_vld_q;

	// commands
	always_comb begin
		cmd          = '0;
		cmd.start    = accept;
		cmd.issue    = (state_q == ST_RUN) && !sts.found;
		cmd.ref_div  = ref_q;
		cmd.pd1      = pd1_q;
		cmd.pd2      = pd2_q;
		cmd.out_load = (state_q == ST_DONE) && out_free;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (sts.found || last_cand) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!sts.busy) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// candidate sweep: r 2..1, p1 7..1, p2 p1..1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= REF_FIRST;
			pd1_q <= PD_FIRST;
			pd2_q <= PD_FIRST;
		end else if (accept) begin
			ref_q <= REF_FIRST;
			pd1_q <= PD_FIRST;
			pd2_q <= PD_FIRST;
		end else if (cmd.issue && !last_cand) begin
			if (pd2_q != PD_LAST) begin
				pd2_q <= pd2_q - 3'd1;
			end else if (pd1_q != PD_LAST) begin
				pd1_q <= pd1_q - 3'd1;
				pd2_q <= pd1_q - 3'd1;
			end else begin
				ref_q <= REF_LAST;
				pd1_q <= PD_FIRST;
				pd2_q <= PD_FIRST;
			end
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

endmodule

/* rtl/pds_dp.sv */
// ---------------------------------------------------------------------------
// pds_dp
// Datapath: candidate pipeline, result latch, output register.
// ---------------------------------------------------------------------------
module pds_dp
	import pds_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [TARGET_W-1:0] target_freq_q8,
	input  cmd_t                cmd,
	output sts_t                sts,
	output res_t                res
);

	localparam int HALF_W = 5 + FRAC_BITS;
	localparam int XW     = ((NUM_W > HALF_W) ? NUM_W : HALF_W) + 1;
	localparam int GW     = 13 + FRAC_BITS;
	localparam int DW     = ((NUM_W > GW) ? NUM_W : GW) + 1;
	localparam int QM_W   = V_W + 11;
	localparam logic [XW-1:0] HALF = XW'(REF_CLK_MHZ) << (FRAC_BITS - 1);

	logic [TARGET_W-1:0] t_q;

	// stage 1: product
	logic             vld_s1;
	logic [PROD_W-1:0] prod_s1;
	logic [REF_W-1:0] ref_s1;
	logic [PD_W-1:0]  pd1_s1, pd2_s1;

	// stage 2: scaled target
	logic             vld_s2;
	logic [NUM_W-1:0] num_s2;
	logic [PROD_W-1:0] prod_s2;
	logic [REF_W-1:0] ref_s2;
	logic [PD_W-1:0]  pd1_s2, pd2_s2;

	// stage 3: rounded feedback divider
	logic             vld_s3;
	logic             inr_s3;
	logic [FB_W-1:0]  fb_s3;
	logic [NUM_W-1:0] num_s3;
	logic [PROD_W-1:0] prod_s3;
	logic [REF_W-1:0] ref_s3;
	logic [PD_W-1:0]  pd1_s3, pd2_s3;

	// result latch
	logic found_q;
	res_t hit_q;
	res_t out_q;

	logic [XW-1:0]   x_sum, y_val;
	logic            in_range;
	logic [V_W-1:0]  v_off;
	logic [QM_W-1:0] qm;
	logic [Q_W-1:0]  q_val;
	logic [GW-1:0]   got_fb;
	logic [DW-1:0]   num_ext, got_ext, diff, lim;
	logic            hit;
	logic [12:0]     vco_fb, vco_lim;
	res_t            hit_res;

	// target load
	always_ff @(posedge clk) begin
		if (cmd.start) t_q <= target_freq_q8;
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// stage 1
	always_ff @(posedge clk) begin
		prod_s1 <= prod_of(cmd.ref_div, cmd.pd1, cmd.pd2);
		ref_s1  <= cmd.ref_div;
		pd1_s1  <= cmd.pd1;
		pd2_s1  <= cmd.pd2;
	end

	// stage 2: P * t
	always_ff @(posedge clk) begin
		num_s2  <= NUM_W'(prod_s1) * NUM_W'(t_q);
		prod_s2 <= prod_s1;
		ref_s2  <= ref_s1;
		pd1_s2  <= pd1_s1;
		pd2_s2  <= pd2_s1;
	end

	// stage 3: fb = floor((P*t + 12.5*2^F) / (25*2^F)), range check
	assign x_sum    = XW'(num_s2) + HALF;
	assign y_val    = x_sum >> FRAC_BITS;
	assign in_range = (y_val >= XW'(Y_LO)) && (y_val < XW'(Y_HI));
	assign v_off    = V_W'(y_val - XW'(Y_LO));
	assign qm       = QM_W'(v_off) * QM_W'(RECIP_M);
	assign q_val    = Q_W'(qm >> RECIP_S);

	always_ff @(posedge clk) begin
		inr_s3  <= in_range;
		fb_s3   <= FB_W'(FB_MIN) + FB_W'(q_val);
		num_s3  <= num_s2;
		prod_s3 <= prod_s2;
		ref_s3  <= ref_s2;
		pd1_s3  <= pd1_s2;
		pd2_s3  <= pd2_s2;
	end

	// error check: |P*t - 25*fb*2^F| < P*2^F
	assign got_fb  = GW'(fb_s3) * GW'(REF_CLK_MHZ);
	assign num_ext = DW'(num_s3);
	assign got_ext = DW'(got_fb) << FRAC_BITS;
	assign diff    = (num_ext >= got_ext) ? (num_ext - got_ext) : (got_ext - num_ext);
	assign lim     = DW'(prod_s3) << FRAC_BITS;
	assign hit     = vld_s3 && inr_s3 && (diff < lim);

	// result fields of the hit candidate
	assign vco_fb  = 13'(fb_s3) * 13'(REF_CLK_MHZ);
	assign vco_lim = 13'(VCO_LIMIT) * 13'(ref_s3);

	always_comb begin
		hit_res                     = '0;
		hit_res.found               = 1'b1;
		hit_res.feedback_divider    = fb_s3;
		hit_res.reference_divider   = ref_s3;
		hit_res.post_divider_first  = pd1_s3;
		hit_res.post_divider_second = pd2_s3;
		hit_res.post_divider_byte   = {1'b0, pd1_s3 - 3'd1, 1'b0, pd2_s3 - 3'd1};
		hit_res.high_vco            = (vco_fb >= vco_lim);
	end

	// first hit wins; later candidates in flight are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.start) begin
			found_q <= 1'b0;
		end else if (hit) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			hit_q <= '0;
		end else if (hit && !found_q) begin
			hit_q <= hit_res;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) out_q <= hit_q;
	end

	assign sts.found = found_q;
	assign sts.busy  = vld_s1 || vld_s2 || vld_s3;
	assign res       = out_q;

endmodule

/* rtl/pll_divider_search_core.sv */
// ---------------------------------------------------------------------------
// pll_divider_search_core
// Finds PLL reference, feedback and post dividers for a target frequency.
// ---------------------------------------------------------------------------
//  channel  | dir | fields
//  s_*      | in  | target_freq_q8
//  m_*      | out | found, feedback_divider, reference_divider, post dividers,
//           |     | post_divider_byte, high_vco
//
// An item is accepted, then the candidates are swept (up to 56, fewer when a
// hit stops the sweep), the pipeline drains and the output register is
// loaded. Reset is asynchronous and clears control only. A stalled output
// holds; the next item is searched meanwhile and loaded once it is taken.
// ---------------------------------------------------------------------------
`include "pll_divider_search_core_assert.svh"

module pll_divider_search_core
	import pds_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // [17:0] target_freq_q8
	output logic                m_tvalid,
	input  logic                m_tready,
	// [0] found, [8:1] feedback_divider, [10:9] reference_divider,
	// [13:11] post_divider_first, [16:14] post_divider_second,
	// [24:17] post_divider_byte, [25] high_vco
	output logic [M_DATA_W-1:0] m_tdata
);

	cmd_t cmd;
	sts_t sts;
	res_t res;
	logic fb_ok;

	// controller
	pds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// datapath
	pds_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.target_freq_q8 (s_tdata[TARGET_W-1:0]),
		.cmd            (cmd),
		.sts            (sts),
		.res            (res)
	);

	assign m_tdata = M_DATA_W'(res);

	// feedback divider inside its legal span
	assign fb_ok = (res.feedback_divider >= FB_W'(FB_MIN)) &&
		(res.feedback_divider <= FB_W'(FB_MAX));

	// checks
	`PDS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready after accept")
	`PDS_ASSERT_SAME(a_fb_range, m_tvalid && res.found, fb_ok, "feedback divider out of range")
	`PDS_ASSERT_SAME(a_miss_zero, m_tvalid && !res.found, m_tdata == '0, "miss not zero")

endmodule

/* dv/pll_divider_search_core_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pll_divider_search_core_tb
// Streams target frequencies into the divider search core and checks every
// result against an in-bench search over the same candidate order, under
// several input/output idling mixes and one long output hold-off.
// ---------------------------------------------------------------------------
module pll_divider_search_core_tb
	import pds_pkg::*;
();

	localparam int TB_FRAC   = FRAC_BITS_DEF;
	localparam int HALF_CLK  = 10;
	localparam int RST_CYC   = 9;
	localparam int PHASE_N   = 125;
	localparam int HOLD_LEN  = 400;
	localparam int DRAIN_CYC = 80;
	localparam int STALL_MAX = 2000;
	localparam int T_MAX     = (1 << TARGET_W) - 1;

	// expected results of the divider search, in order of acceptance
	class divider_board;
		res_t expected_q[$];
		int errors;

		// sweep r = 2..1, p1 = 7..1, p2 = 7..1 (p2 <= p1), take the first hit
		function res_t search_dividers(logic [TARGET_W-1:0] target);
			res_t res;
			longint unsigned one, prod, num, fb, got, diff;
			int r, p1, p2;
			bit done;
			res = '0;
			one = longint'(1) << TB_FRAC;
			done = 0;
			for (r = 2; r >= 1; r--) begin
				for (p1 = 7; p1 >= 1; p1--) begin
					for (p2 = 7; p2 >= 1; p2--) begin
						if (!done && p2 <= p1) begin
							prod = r * p1 * p2;
							num = prod * target;
							// round half up
							fb = (2 * num + REF_CLK_MHZ * one) / (2 * REF_CLK_MHZ * one);
							if (fb >= FB_MIN && fb <= FB_MAX) begin
								got = REF_CLK_MHZ * fb * one;
								diff = (num >= got) ? num - got : got - num;
								if (diff < prod * one) begin
									done = 1;
									res.found = 1'b1;
									res.feedback_divider = FB_W'(fb);
									res.reference_divider = REF_W'(r);
									res.post_divider_first = PD_W'(p1);
									res.post_divider_second = PD_W'(p2);
									res.post_divider_byte = {4'(p1 - 1), 4'(p2 - 1)};
									res.high_vco = (fb * REF_CLK_MHZ >= VCO_LIMIT * r);
								end
							end
						end
					end
				end
			end
			return res;
		endfunction

		function void note_target(logic [TARGET_W-1:0] target);
			expected_q.push_back(search_dividers(target));
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		task report(string what);
			$display("ERROR @%0t: %s", $time, what);
			errors++;
		endtask

		task check_field(string name, int got, int want);
			if (got != want)
				report($sformatf("%s got %0d expected %0d", name, got, want));
		endtask

		task check_result(logic [M_DATA_W-1:0] data);
			res_t got, want;
			got = data[RES_W-1:0];
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result item 0x%0h", data));
			end else begin
				want = expected_q.pop_front();
				check_field("found", got.found, want.found);
				check_field("feedback_divider", got.feedback_divider, want.feedback_divider);
				check_field("reference_divider", got.reference_divider,
					want.reference_divider);
				check_field("post_divider_first", got.post_divider_first,
					want.post_divider_first);
				check_field("post_divider_second", got.post_divider_second,
					want.post_divider_second);
				check_field("post_divider_byte", got.post_divider_byte,
					want.post_divider_byte);
				check_field("high_vco", got.high_vco, want.high_vco);
			end
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;   // [17:0] target_freq_q8
	logic                m_tvalid;
	logic                m_tready;
	// [0] found, [8:1] feedback_divider, [10:9] reference_divider,
	// [13:11] post_divider_first, [16:14] post_divider_second,
	// [24:17] post_divider_byte, [25] high_vco
	logic [M_DATA_W-1:0] m_tdata;

	divider_board board;
	int send_idle_pct;
	int sink_stall_pct;
	bit hold_phase;

	pll_divider_search_core #(
		.FRAC_BITS(TB_FRAC)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	// 20 ns clock
	initial clk = 1'b0;
	always begin
		#HALF_CLK clk = 1'b1;
		#HALF_CLK clk = 1'b0;
	end

	// offer one target, with random gap ahead of it; returns at the falling
	// edge after acceptance with tvalid still high
	task send_target(input logic [TARGET_W-1:0] target);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= S_DATA_W'(target);
		do @(posedge clk); while (!s_tready);
		board.note_target(target);
		@(negedge clk);
	endtask

	// random target: mostly near an achievable frequency, some anywhere,
	// some too low to be found
	function automatic logic [TARGET_W-1:0] pick_target();
		int mode, r, p1, p2, prod, fb, t;
		mode = $urandom_range(99);
		if (mode < 45) begin
			r = $urandom_range(2, 1);
			p1 = $urandom_range(7, 1);
			p2 = $urandom_range(p1, 1);
			prod = r * p1 * p2;
			fb = $urandom_range(FB_MAX, FB_MIN);
			t = (REF_CLK_MHZ * fb * (1 << TB_FRAC) + prod / 2) / prod;
			// step around the 1 MHz window edge
			t = t + $urandom_range(2 * 270, 0) - 270;
			if (t < 0)
				t = 0;
			if (t > T_MAX)
				t = T_MAX;
			return TARGET_W'(t);
		end else if (mode < 75) begin
			return TARGET_W'($urandom_range(T_MAX, 40 << TB_FRAC));
		end else if (mode < 93) begin
			return TARGET_W'($urandom_range(T_MAX, 0));
		end else begin
			return TARGET_W'($urandom_range((40 << TB_FRAC) + 1000, 0));
		end
	endfunction

	// output ready: random stalls, one long hold-off during the pressure phase
	initial begin
		int held;
		bit hold_done;
		held = 0;
		hold_done = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_phase && !hold_done) begin
				m_tready <= 1'b0;
				held++;
				if (held >= HOLD_LEN)
					hold_done = 1;
			end else begin
				m_tready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	// check accepted results
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tdata);
	end

	// watchdog on cycles with no item moving on either side
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_MAX) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// main sequence
	initial begin
		logic [TARGET_W-1:0] directed[$];
		int phase_send[4];
		int phase_sink[4];
		board = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		send_idle_pct = 0;
		sink_stall_pct = 0;
		hold_phase = 0;
		phase_send = '{0, 55, 0, 32};
		phase_sink = '{0, 0, 55, 32};
		// zero, extremes, bit patterns, lowest findable, rounding half,
		// high VCO boundary at r = 2, round frequencies
		directed = '{18'd0, 18'd1, 18'h3FFFF, 18'h3FFFE, 18'h20000, 18'h2AAAA,
			18'h15555, 18'd10449, 18'd10450, 18'd11200, 18'd12473, 18'd12539,
			18'd25600, 18'd65536, 18'd153600, 18'd204800, 18'd170667,
			18'd255999, 18'd9000};

		repeat (RST_CYC) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i])
			send_target(directed[i]);

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = phase_send[ph];
			sink_stall_pct = phase_sink[ph];
			// fill the block while the output is held off
			if (ph == 0)
				hold_phase = 1;
			for (int n = 0; n < PHASE_N; n++)
				send_target(pick_target());
		end
		s_tvalid <= 1'b0;

		while (board.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		if (board.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
